// ===== hw/rtl/dcyf_pkg.sv =====
// Shared types, constants and date helper functions for the day-count / year-fraction block.
package dcyf_pkg;

    // Largest accepted calendar year
    localparam int unsigned MAX_YEAR = 9999;

    // Field widths
    localparam int unsigned CNT_W  = 22;
    localparam int unsigned FRAC_W = 46;
    localparam int unsigned SER_W  = 24;  // serial day numbers and raw counts

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // x / 25 for x < 8192 as (x * DIV25_MUL) >> DIV25_SHIFT
    localparam logic [15:0] DIV25_MUL   = 16'd41944;
    localparam int unsigned DIV25_SHIFT = 20;

    // 2^32 = D * Q + R; floor(R * n / D) via (R * n * M) >> RECIP_SHIFT
    localparam logic [23:0] Q365 = 24'd11767033;
    localparam logic [23:0] Q360 = 24'd11930464;
    localparam logic [8:0]  R365 = 9'd251;
    localparam logic [8:0]  R360 = 9'd256;
    localparam logic [31:0] M365 = 32'd3012360625;
    localparam logic [31:0] M360 = 32'd3054198967;
    localparam int unsigned RECIP_SHIFT = 40;

    // Days before the first of a month, counted from March 1
    localparam logic [8:0] CUM_DAYS [16] = '{
        9'd0,   9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd0,   9'd0,   9'd0
    };

    typedef enum logic [1:0] {
        OP_ACT365 = 2'd0,
        OP_ACT360 = 2'd1,
        OP_30360  = 2'd2,
        OP_30E360 = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_ORDER    = 2'd2
    } t_status;

    // Word passed from the count pipeline to the fraction pipeline
    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] count;
        logic             use360;
    } t_cnt_word;

    // floor(v / 100), v below 16784
    function automatic logic [7:0] div100(input logic [14:0] v);
        logic [29:0] prod;
        prod = 30'(v[14:2]) * 30'(DIV25_MUL);
        return prod[DIV25_SHIFT +: 8];
    endfunction

    // Gregorian leap rule; c is y / 100
    function automatic logic is_leap(input logic [13:0] y, input logic [7:0] c);
        logic not_century;
        not_century = (13'(y[13:2]) != 13'(c) * 13'd25);
        return (y[1:0] == 2'd0) && (not_century || (c[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                     input logic [4:0] d, input logic [7:0] c);
        return (32'(y) <= MAX_YEAR) && (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1)
            && (d <= month_len(m, is_leap(y, c)));
    endfunction

    // Day number; yy is the March-based year plus 400, h is yy / 100
    function automatic logic [SER_W-1:0] serial_day(input logic [14:0] yy,
                                                    input logic [7:0] h,
                                                    input logic [3:0] m,
                                                    input logic [4:0] d);
        return SER_W'(yy) * SER_W'(365) + SER_W'(yy[14:2]) - SER_W'(h)
            + SER_W'(h[7:2]) + SER_W'(CUM_DAYS[m]) + SER_W'(d) - SER_W'(1);
    endfunction

endpackage

// ===== hw/rtl/dcyf_count.sv =====
// Three-stage pipeline: date capture, year division, validation and day count.
module dcyf_count (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_opcode,
    input  logic [13:0]         i_start_year,
    input  logic [3:0]          i_start_month,
    input  logic [4:0]          i_start_day,
    input  logic [13:0]         i_end_year,
    input  logic [3:0]          i_end_month,
    input  logic [4:0]          i_end_day,
    output logic                o_valid,
    input  logic                i_ready,
    output dcyf_pkg::t_cnt_word o_word
);
    import dcyf_pkg::*;

    logic en1, en2, en3;

    // Stage 1: input capture
    logic        r_v1;
    t_op         r_op;
    logic [13:0] r_y1, r_y2;
    logic [3:0]  r_m1, r_m2;
    logic [4:0]  r_d1, r_d2;

    // Stage 2: March-based years and their divisions by 100
    logic        r_v2;
    t_op         r2_op;
    logic [13:0] r2_y1, r2_y2;
    logic [3:0]  r2_m1, r2_m2;
    logic [4:0]  r2_d1, r2_d2;
    logic [14:0] r2_yy1, r2_yy2;
    logic [7:0]  r2_h1, r2_h2, r2_c1, r2_c2;
    logic        r2_lt;
    logic [14:0] n_yy1, n_yy2;

    // Stage 3: result word
    logic        r_v3;
    t_cnt_word   r_word, n_word;

    logic [4:0]       adj_a, adj_b;
    logic [SER_W-1:0] ser1, ser2, cnt_act, cnt_30, cnt_raw;
    logic [CNT_W-1:0] cnt_sat;
    logic             ok1, ok2;

    // Pipeline advance: a stage loads when empty or when its word moves on
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op <= t_op'(i_opcode);
            r_y1 <= i_start_year;
            r_m1 <= i_start_month;
            r_d1 <= i_start_day;
            r_y2 <= i_end_year;
            r_m2 <= i_end_month;
            r_d2 <= i_end_day;
        end
    end

    // Years counted from March, offset by 400 so nothing goes negative
    assign n_yy1 = 15'(r_y1) + 15'd400 - ((r_m1 <= 4'd2) ? 15'd1 : 15'd0);
    assign n_yy2 = 15'(r_y2) + 15'd400 - ((r_m2 <= 4'd2) ? 15'd1 : 15'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_op  <= r_op;
            r2_y1  <= r_y1;
            r2_m1  <= r_m1;
            r2_d1  <= r_d1;
            r2_y2  <= r_y2;
            r2_m2  <= r_m2;
            r2_d2  <= r_d2;
            r2_yy1 <= n_yy1;
            r2_yy2 <= n_yy2;
            r2_h1  <= div100(n_yy1);
            r2_h2  <= div100(n_yy2);
            r2_c1  <= div100(15'(r_y1));
            r2_c2  <= div100(15'(r_y2));
            r2_lt  <= ({r_y2, r_m2, r_d2} < {r_y1, r_m1, r_d1});
        end
    end

    // Date checks
    assign ok1 = date_ok(r2_y1, r2_m1, r2_d1, r2_c1);
    assign ok2 = date_ok(r2_y2, r2_m2, r2_d2, r2_c2);

    // Actual day count
    assign ser1    = serial_day(r2_yy1, r2_h1, r2_m1, r2_d1);
    assign ser2    = serial_day(r2_yy2, r2_h2, r2_m2, r2_d2);
    assign cnt_act = ser2 - ser1;

    // 30/360 day adjustments; 30E/360 caps both days
    assign adj_a = (r2_d1 == 5'd31) ? 5'd30 : r2_d1;
    assign adj_b = ((r2_d2 == 5'd31) && ((r2_op == OP_30E360) || (adj_a == 5'd30)))
                 ? 5'd30 : r2_d2;

    // Modulo arithmetic is exact here since ordered dates keep the sum small
    assign cnt_30 = (SER_W'(r2_y2) - SER_W'(r2_y1)) * SER_W'(360)
                  + SER_W'(r2_m2) * SER_W'(30) + SER_W'(adj_b)
                  - SER_W'(r2_m1) * SER_W'(30) - SER_W'(adj_a);

    assign cnt_raw = ((r2_op == OP_ACT365) || (r2_op == OP_ACT360)) ? cnt_act : cnt_30;
    assign cnt_sat = (cnt_raw > SER_W'(COUNT_MAX)) ? COUNT_MAX : cnt_raw[CNT_W-1:0];

    // Status priority: bad date, then order
    always_comb begin
        n_word.use360 = (r2_op != OP_ACT365);
        priority if (!ok1 || !ok2) begin
            n_word.status = ST_BAD_DATE;
            n_word.count  = '0;
        end else if (r2_lt) begin
            n_word.status = ST_ORDER;
            n_word.count  = '0;
        end else begin
            n_word.status = ST_OK;
            n_word.count  = cnt_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_v3;
    assign o_word  = r_word;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("count pipeline not empty after reset");

    // Error words carry a zero count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_word.status != ST_OK) |-> (o_word.count == '0))
        else $error("nonzero count on error word");

    // Input stalls only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with an empty stage");

endmodule

// ===== hw/rtl/dcyf_frac.sv =====
// Three-stage pipeline turning a day count into a UQ14.32 year fraction.
module dcyf_frac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dcyf_pkg::t_cnt_word i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [21:0]         o_day_count,
    output logic [45:0]         o_year_fraction
);
    import dcyf_pkg::*;

    logic en4, en5, en6;

    // Stage 4: count * Q and count * R
    logic              r_v4;
    t_status           r4_status;
    logic [CNT_W-1:0]  r4_count;
    logic              r4_use360;
    logic [FRAC_W-1:0] r4_p1;
    logic [30:0]       r4_x;

    // Stage 5: floor(count * R / D) by reciprocal
    logic              r_v5;
    t_status           r5_status;
    logic [CNT_W-1:0]  r5_count;
    logic [FRAC_W-1:0] r5_p1;
    logic [22:0]       r5_y;
    logic [62:0]       prod_m;

    // Stage 6: output register
    logic              r_v6;
    t_status           r6_status;
    logic [CNT_W-1:0]  r6_count;
    logic [FRAC_W-1:0] r6_frac;

    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // Split 2^32 / D into quotient and remainder parts
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_status <= i_word.status;
            r4_count  <= i_word.count;
            r4_use360 <= i_word.use360;
            r4_p1     <= FRAC_W'(i_word.count) * FRAC_W'(i_word.use360 ? Q360 : Q365);
            r4_x      <= 31'(i_word.count) * 31'(i_word.use360 ? R360 : R365);
        end
    end

    assign prod_m = 63'(r4_x) * 63'(r4_use360 ? M360 : M365);

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_status <= r4_status;
            r5_count  <= r4_count;
            r5_p1     <= r4_p1;
            r5_y      <= prod_m[RECIP_SHIFT +: 23];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_status <= r5_status;
            r6_count  <= r5_count;
            r6_frac   <= r5_p1 + FRAC_W'(r5_y);
        end
    end

    assign o_valid         = r_v6;
    assign o_status        = r6_status;
    assign o_day_count     = r6_count;
    assign o_year_fraction = r6_frac;

    // Divisor is at least 360, so the integer part never exceeds the count
    a_int_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_fraction[45:32] <= o_day_count))
        else $error("year fraction integer part above day count");

    // Zero count gives zero fraction
    a_zero_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_day_count == '0) |-> (o_year_fraction == '0))
        else $error("nonzero fraction for zero count");

    // A nonzero count gives a nonzero fraction
    a_nonzero_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_day_count != '0) |-> (o_year_fraction != '0))
        else $error("zero fraction for nonzero count");

endmodule

// ===== hw/rtl/day_count_year_fraction.sv =====
// Top level of the day-count / year-fraction block: count pipeline feeding fraction pipeline.
// A word accepted at the input passes through every pipeline register in turn before it is presented on the output.
// Throughput: one word per cycle while the output is not stalled; six pipeline registers, each with its own valid bit.
// Output stall backs up stage by stage; the input stalls only when all stages are full.
// Reset (synchronous, active low) clears every valid bit; payload registers are not reset.
module day_count_year_fraction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [13:0] i_start_year,
    input  logic [3:0]  i_start_month,
    input  logic [4:0]  i_start_day,
    input  logic [13:0] i_end_year,
    input  logic [3:0]  i_end_month,
    input  logic [4:0]  i_end_day,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [21:0] o_day_count,
    output logic [45:0] o_year_fraction
);
    import dcyf_pkg::*;

    t_cnt_word cnt_word;
    logic      cnt_valid;
    logic      cnt_ready;

    // Date checks and day count
    dcyf_count u_count (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_end_year    (i_end_year),
        .i_end_month   (i_end_month),
        .i_end_day     (i_end_day),
        .o_valid       (cnt_valid),
        .i_ready       (cnt_ready),
        .o_word        (cnt_word)
    );

    // Year fraction
    dcyf_frac u_frac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (cnt_valid),
        .o_ready         (cnt_ready),
        .i_word          (cnt_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_day_count     (o_day_count),
        .o_year_fraction (o_year_fraction)
    );

endmodule

// ===== sim/day_count_year_fraction_test.sv =====
// Self-checking testbench for the day-count / year-fraction block.
module day_count_year_fraction_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dcyf_pkg::*;

    localparam int unsigned RANDOM_WORDS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned HOLD_AFTER   = 300;
    localparam int unsigned COUNT_SAT    = 4194303;

    // One date pair as offered on the input
    typedef struct {
        t_op         op;
        logic [13:0] sy;
        logic [3:0]  sm;
        logic [4:0]  sd;
        logic [13:0] ey;
        logic [3:0]  em;
        logic [4:0]  ed;
    } t_date_pair;

    // One result word
    typedef struct {
        t_status     status;
        logic [21:0] count;
        logic [45:0] frac;
    } t_yf_word;

    // Directed row: typed marks an expectation written in by hand
    typedef struct {
        t_op         op;
        logic [13:0] sy;
        logic [3:0]  sm;
        logic [4:0]  sd;
        logic [13:0] ey;
        logic [3:0]  em;
        logic [4:0]  ed;
        bit          typed;
        t_status     st;
        logic [21:0] cnt;
        logic [45:0] frac;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [13:0] i_start_year;
    logic [3:0]  i_start_month;
    logic [4:0]  i_start_day;
    logic [13:0] i_end_year;
    logic [3:0]  i_end_month;
    logic [4:0]  i_end_day;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [21:0] o_day_count;
    logic [45:0] o_year_fraction;

    t_yf_word    fractions_due [$];
    t_yf_word    want;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned words_sent;
    int unsigned ok_seen;
    int unsigned bad_date_seen;
    int unsigned order_seen;
    int unsigned backed_up_cycles;
    int unsigned cycles;
    bit          hold_active;
    bit          hold_done;

    t_dir_row directed_rows [25] = '{
        '{OP_ACT365, 2000, 1, 1, 2000, 1, 1, 1'b1, ST_OK, 0, 0},
        '{OP_ACT360, 0, 1, 1, 9999, 12, 31, 1'b0, ST_OK, 0, 0},
        '{OP_ACT365, 0, 1, 1, 9999, 12, 31, 1'b0, ST_OK, 0, 0},
        '{OP_30360, 0, 1, 1, 9999, 12, 31, 1'b0, ST_OK, 0, 0},
        '{OP_30E360, 0, 1, 31, 9999, 12, 31, 1'b0, ST_OK, 0, 0},
        '{OP_ACT365, 2024, 3, 1, 2024, 2, 29, 1'b1, ST_ORDER, 0, 0},
        '{OP_ACT360, 2023, 2, 29, 2023, 3, 1, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_ACT365, 1900, 2, 29, 1900, 3, 1, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_ACT360, 2000, 2, 29, 2000, 3, 1, 1'b0, ST_OK, 0, 0},
        '{OP_30360, 0, 2, 29, 0, 3, 1, 1'b0, ST_OK, 0, 0},
        '{OP_ACT365, 10000, 1, 1, 10000, 1, 2, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_ACT365, 16383, 15, 31, 16383, 15, 31, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_30E360, 2020, 0, 10, 2020, 5, 10, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_ACT360, 2020, 1, 1, 2020, 13, 1, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_30360, 2020, 4, 31, 2020, 5, 1, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_30E360, 2020, 3, 1, 2020, 4, 0, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_30360, 2021, 1, 31, 2021, 3, 31, 1'b0, ST_OK, 0, 0},
        '{OP_30360, 2021, 1, 30, 2021, 3, 31, 1'b0, ST_OK, 0, 0},
        '{OP_30360, 2021, 1, 29, 2021, 3, 31, 1'b0, ST_OK, 0, 0},
        '{OP_30E360, 2021, 1, 29, 2021, 3, 31, 1'b0, ST_OK, 0, 0},
        '{OP_30E360, 2021, 2, 28, 2021, 3, 31, 1'b0, ST_OK, 0, 0},
        '{OP_ACT365, 2021, 6, 15, 2021, 6, 14, 1'b1, ST_ORDER, 0, 0},
        '{OP_ACT360, 2021, 5, 1, 2020, 13, 1, 1'b1, ST_BAD_DATE, 0, 0},
        '{OP_ACT365, 0, 1, 1, 0, 1, 1, 1'b1, ST_OK, 0, 0},
        '{OP_30E360, 9999, 12, 31, 9999, 12, 31, 1'b1, ST_OK, 0, 0}
    };

    day_count_year_fraction dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_start_year    (i_start_year),
        .i_start_month   (i_start_month),
        .i_start_day     (i_start_day),
        .i_end_year      (i_end_year),
        .i_end_month     (i_end_month),
        .i_end_day       (i_end_day),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_day_count     (o_day_count),
        .o_year_fraction (o_year_fraction)
    );

    // ---------------------------------------------------------------
    // Calendar arithmetic for the predictor
    // ---------------------------------------------------------------
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            2:             len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    function automatic bit valid_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        if (y > MAX_YEAR || m < 1 || m > 12 || d < 1)
            return 1'b0;
        return d <= days_in_month(y, m);
    endfunction

    // Days from March 1 to the first of month index mi (0 = March)
    function automatic int unsigned days_before_month(input int unsigned mi);
        int unsigned n;
        case (mi)
            0:       n = 0;
            1:       n = 31;
            2:       n = 61;
            3:       n = 92;
            4:       n = 122;
            5:       n = 153;
            6:       n = 184;
            7:       n = 214;
            8:       n = 245;
            9:       n = 275;
            10:      n = 306;
            default: n = 337;
        endcase
        return n;
    endfunction

    // Absolute day number; the year runs March to February, shifted up 400 years
    function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned ys;
        ys = y + 400 - ((m < 3) ? 1 : 0);
        return 365 * ys + ys / 4 - ys / 100 + ys / 400 + days_before_month((m + 9) % 12) + d;
    endfunction

    // Expected result word for one date pair
    function automatic t_yf_word predict_word(input t_date_pair p);
        t_yf_word    r;
        int          span;
        int          a;
        int          b;
        int unsigned divisor;
        logic [63:0] scaled;
        r.status = ST_OK;
        r.count  = '0;
        r.frac   = '0;
        if (!valid_date(32'(p.sy), 32'(p.sm), 32'(p.sd))
                || !valid_date(32'(p.ey), 32'(p.em), 32'(p.ed))) begin
            r.status = ST_BAD_DATE;
            return r;
        end
        if ({p.ey, p.em, p.ed} < {p.sy, p.sm, p.sd}) begin
            r.status = ST_ORDER;
            return r;
        end
        if (p.op == OP_ACT365 || p.op == OP_ACT360) begin
            span = int'(day_number(32'(p.ey), 32'(p.em), 32'(p.ed)))
                 - int'(day_number(32'(p.sy), 32'(p.sm), 32'(p.sd)));
        end else begin
            // 30-day months: the 31st folds onto the 30th
            a = int'(p.sd);
            b = int'(p.ed);
            if (a == 31)
                a = 30;
            if (b == 31 && (p.op == OP_30E360 || a == 30))
                b = 30;
            span = 360 * (int'(p.ey) - int'(p.sy)) + 30 * (int'(p.em) - int'(p.sm)) + b - a;
        end
        if (span > int'(COUNT_SAT))
            span = int'(COUNT_SAT);
        divisor = (p.op == OP_ACT365) ? 365 : 360;
        r.count = 22'(span);
        scaled  = 64'(r.count) << 32;
        r.frac  = 46'(scaled / 64'(divisor));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // Mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned pick_year();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1950, 2100);
        if (r < 80)
            return $urandom_range(0, MAX_YEAR);
        if (r < 90)
            return $urandom_range(0, 8);
        return 100 * $urandom_range(0, MAX_YEAR / 100);
    endfunction

    // Month ends and the first are favored
    function automatic int unsigned pick_day(input int unsigned y, input int unsigned m);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return days_in_month(y, m);
        if (r < 40)
            return 1;
        return $urandom_range(1, days_in_month(y, m));
    endfunction

    function automatic t_date_pair random_pair();
        t_date_pair  p;
        int unsigned kind;
        int unsigned span;
        int unsigned y1;
        int unsigned m1;
        int unsigned d1;
        int unsigned y2;
        int unsigned m2;
        int unsigned d2;
        int unsigned tmp;
        bit          later;
        kind = $urandom_range(0, 99);
        p.op = t_op'($urandom_range(0, 3));
        if (kind >= 88 && $urandom_range(0, 1) == 0) begin
            // Raw noise over the full field ranges
            p.sy = 14'($urandom);
            p.sm = 4'($urandom);
            p.sd = 5'($urandom);
            p.ey = 14'($urandom);
            p.em = 4'($urandom);
            p.ed = 5'($urandom);
            return p;
        end
        y1 = pick_year();
        m1 = $urandom_range(1, 12);
        d1 = pick_day(y1, m1);
        span = $urandom_range(0, 9);
        if (span < 5)
            y2 = y1 + $urandom_range(0, 1);
        else if (span < 8)
            y2 = y1 + $urandom_range(0, 40);
        else
            y2 = $urandom_range(0, MAX_YEAR);
        if (y2 > MAX_YEAR)
            y2 = MAX_YEAR;
        m2 = (span < 3) ? m1 : $urandom_range(1, 12);
        d2 = pick_day(y2, m2);
        later = ({14'(y2), 4'(m2), 5'(d2)} >= {14'(y1), 4'(m1), 5'(d1)});
        // Ordered pairs mostly, reversed pairs sometimes
        if ((kind < 75 && !later) || (kind >= 75 && later)) begin
            tmp = y1; y1 = y2; y2 = tmp;
            tmp = m1; m1 = m2; m2 = tmp;
            tmp = d1; d1 = d2; d2 = tmp;
        end
        p.sy = 14'(y1);
        p.sm = 4'(m1);
        p.sd = 5'(d1);
        p.ey = 14'(y2);
        p.em = 4'(m2);
        p.ed = 5'(d2);
        // Broken pair: end day just past the month
        if (kind >= 88)
            p.ed = 5'(days_in_month(y2, m2) + 1);
        return p;
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input t_date_pair p, input bit typed, input t_yf_word typed_word);
        @(negedge i_clk);
        i_opcode      = p.op;
        i_start_year  = p.sy;
        i_start_month = p.sm;
        i_start_day   = p.sd;
        i_end_year    = p.ey;
        i_end_month   = p.em;
        i_end_day     = p.ed;
        i_valid       = 1'b1;
        do
            @(posedge i_clk);
        while (!o_ready);
        fractions_due.push_back(typed ? typed_word : predict_word(p));
        words_sent++;
    endtask

    task automatic idle_for(input int unsigned n);
        if (n != 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering until every pending result is out
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (fractions_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Clock and cycle limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycles, fractions_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Output side: random stalls plus one long hold-off
    // ---------------------------------------------------------------
    initial begin
        bit          ready_on;
        int unsigned phase_left;
        ready_on    = 1'b0;
        phase_left  = 0;
        i_ready     = 1'b0;
        hold_active = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_active = 1'b1;
                i_ready     = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
                phase_left  = 0;
            end else begin
                if (phase_left == 0) begin
                    ready_on = !ready_on;
                    if (ready_on)
                        phase_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                                 : $urandom_range(1, 12);
                    else
                        phase_left = 1 + pause_len();
                end
                i_ready = ready_on;
                phase_left--;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result check against the oldest pending word
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_ready)
            backed_up_cycles++;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (fractions_due.size() == 0) begin
                $error("result word with nothing pending: status %0d count %0d",
                       o_status, o_day_count);
                mismatches++;
            end else begin
                want = fractions_due.pop_front();
                case (want.status)
                    ST_OK:       ok_seen++;
                    ST_BAD_DATE: bad_date_seen++;
                    default:     order_seen++;
                endcase
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_day_count !== want.count) begin
                    $error("day count: expected %0d, got %0d", want.count, o_day_count);
                    mismatches++;
                end
                if (o_year_fraction !== want.frac) begin
                    $error("year fraction: expected %h, got %h", want.frac, o_year_fraction);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        t_date_pair  p;
        t_yf_word    typed_word;
        int unsigned burst_left;
        mismatches       = 0;
        results_seen     = 0;
        words_sent       = 0;
        ok_seen          = 0;
        bad_date_seen    = 0;
        order_seen       = 0;
        backed_up_cycles = 0;
        burst_left       = 0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_opcode         = '0;
        i_start_year     = '0;
        i_start_month    = '0;
        i_start_day      = '0;
        i_end_year       = '0;
        i_end_month      = '0;
        i_end_day        = '0;
        typed_word       = '{ST_OK, 22'd0, 46'd0};
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: extremes, every convention, calendar corner cases
        foreach (directed_rows[k]) begin
            p.op = directed_rows[k].op;
            p.sy = directed_rows[k].sy;
            p.sm = directed_rows[k].sm;
            p.sd = directed_rows[k].sd;
            p.ey = directed_rows[k].ey;
            p.em = directed_rows[k].em;
            p.ed = directed_rows[k].ed;
            typed_word = '{directed_rows[k].st, directed_rows[k].cnt, directed_rows[k].frac};
            send_word(p, directed_rows[k].typed, typed_word);
            if ($urandom_range(0, 3) == 0)
                idle_for(pause_len());
        end
        drain();

        // Random pairs; bursts with no gaps, no gaps while the output is held
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2)
                drain();
            if (burst_left == 0 && $urandom_range(0, 39) == 0)
                burst_left = $urandom_range(40, 120);
            send_word(random_pair(), 1'b0, typed_word);
            if (burst_left != 0)
                burst_left--;
            else if (!hold_active)
                idle_for(pause_len());
        end
        drain();
        repeat (20) @(posedge i_clk);

        $display("%0d words sent, %0d results checked: %0d ok, %0d bad date, %0d out of order",
                 words_sent, results_seen, ok_seen, bad_date_seen, order_seen);
        $display("input backed up for %0d cycles, %0d mismatches", backed_up_cycles, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
